// ===== design/fcrds_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrds_pkg
// Shared types, constants and the masked priority search for the rotating
// fault-code display scan.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrds_pkg;

	localparam int NumCodes      = 100;
	localparam int FlagPositions = 100;
	localparam int FlagsLowW     = 64;
	localparam int FlagsHighW    = FlagPositions - FlagsLowW;
	localparam int CodeW         = $clog2(NumCodes + 1);
	localparam int DwellW        = 16;

	localparam logic [CodeW-1:0]  CodeNone   = CodeW'(NumCodes);
	localparam logic [DwellW-1:0] DwellReset = DwellW'(10);

	typedef logic [FlagPositions-1:0] flags_t;
	typedef logic [CodeW-1:0]         code_t;
	typedef logic [DwellW-1:0]        dwell_t;

	typedef struct packed {
		flags_t flags;
		logic   any_fault;
	} item_t;

	// First set flag at or after start; CodeNone when there is none.
	function automatic code_t find_first(input flags_t flags, input code_t start);
		code_t found;
		found = CodeNone;
		for (int i = FlagPositions - 1; i >= 0; i--) begin
			if ((i < NumCodes) && flags[i] && (CodeW'(i) >= start)) begin
				found = CodeW'(i);
			end
		end
		return found;
	endfunction

endpackage

`default_nettype wire

// ===== design/fcrds_in_reg.sv =====
// ----------------------------------------------------------------------------
// fcrds_in_reg
// Input register stage: captures one item and holds it while downstream stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrds_in_reg (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [fcrds_pkg::FlagsLowW-1:0]       flags_low,
	input  wire  [fcrds_pkg::FlagsHighW-1:0]      flags_high,
	input  wire                                   any_fault,
	output logic                                  valid_s1,
	input  wire                                   stall_s1,
	output fcrds_pkg::item_t                      item_s1
);

	assign in_stall = valid_s1 && stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.flags     <= {flags_high, flags_low};
			item_s1.any_fault <= any_fault;
		end
	end

endmodule

`default_nettype wire

// ===== design/fcrds_core.sv =====
// ----------------------------------------------------------------------------
// fcrds_core
// Scan state, dwell counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrds_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire  [fcrds_pkg::DwellW-1:0]     cfg_wr_data,
	input  wire                              valid_s1,
	output logic                             stall_s1,
	input  wire  fcrds_pkg::item_t           item_s1,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [fcrds_pkg::CodeW-1:0]      shown_code
);

	fcrds_pkg::dwell_t dwell_q;
	fcrds_pkg::dwell_t count_q;
	fcrds_pkg::code_t  scan_q;
	fcrds_pkg::code_t  prev_q;

	fcrds_pkg::code_t  found;
	fcrds_pkg::code_t  scan_srch;
	fcrds_pkg::code_t  scan_step;
	fcrds_pkg::code_t  scan_nxt;
	fcrds_pkg::dwell_t count_inc;
	fcrds_pkg::dwell_t count_nxt;
	fcrds_pkg::code_t  shown_nxt;
	logic              reached;
	logic              advance;
	logic              take;

	assign advance  = !out_valid || !out_stall;
	assign take     = valid_s1 && advance;
	assign stall_s1 = !advance;

	assign found     = fcrds_pkg::find_first(item_s1.flags, scan_q);
	assign scan_srch = (scan_q < fcrds_pkg::CodeNone) ? found : scan_q;
	assign count_inc = ((prev_q != scan_srch) ? '0 : count_q) + fcrds_pkg::DwellW'(1);
	assign reached   = count_inc >= dwell_q;
	assign scan_step = ((fcrds_pkg::CodeW + 1)'(scan_srch) + 1'b1 >
	                    (fcrds_pkg::CodeW + 1)'(fcrds_pkg::NumCodes))
	                   ? '0 : scan_srch + 1'b1;
	assign scan_nxt  = reached ? scan_step : scan_srch;
	assign count_nxt = reached ? '0 : count_inc;
	assign shown_nxt = reached ? fcrds_pkg::CodeNone : scan_srch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= fcrds_pkg::DwellReset;
		end else if (cfg_wr_en) begin
			dwell_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			prev_q    <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				out_valid <= valid_s1;
			end
			if (take && item_s1.any_fault) begin
				scan_q  <= scan_nxt;
				prev_q  <= scan_srch;
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			shown_code <= item_s1.any_fault ? shown_nxt : fcrds_pkg::CodeNone;
		end
	end

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= fcrds_pkg::CodeNone)
		else $error("scan position out of range");

	a_idle_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item_s1.any_fault |=> $stable(scan_q) && $stable(count_q))
		else $error("state changed on a no-fault item");

	a_idle_shows_none: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item_s1.any_fault |=> out_valid && shown_code == fcrds_pkg::CodeNone)
		else $error("no-fault item did not show nothing");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shown_code <= fcrds_pkg::CodeNone)
		else $error("shown code out of range");

endmodule

`default_nettype wire

// ===== design/fault_code_rotating_display_scan_top.sv =====
// ----------------------------------------------------------------------------
// fault_code_rotating_display_scan_top
// Rotating fault-code display scan: steps through set fault flags, showing
// each for a programmable number of refresh ticks.
// ----------------------------------------------------------------------------
// Result path: an accepted item passes the input register, then the result
//   register after the priority search and dwell update.
// Throughput: one item per cycle unless out_stall holds the output; scan state updates in the same cycle.
// Reset: arst_n clears scan position, previous position, dwell count and
//   valids; dwell_q returns to 10.
`default_nettype none

module fault_code_rotating_display_scan_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire  [fcrds_pkg::DwellW-1:0]         cfg_wr_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [fcrds_pkg::FlagsLowW-1:0]      flags_low,
	input  wire  [fcrds_pkg::FlagsHighW-1:0]     flags_high,
	input  wire                                  any_fault,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [fcrds_pkg::CodeW-1:0]          shown_code
);

	logic             valid_s1;
	logic             stall_s1;
	fcrds_pkg::item_t item_s1;

	fcrds_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.flags_low  (flags_low),
		.flags_high (flags_high),
		.any_fault  (any_fault),
		.valid_s1   (valid_s1),
		.stall_s1   (stall_s1),
		.item_s1    (item_s1)
	);

	fcrds_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.valid_s1    (valid_s1),
		.stall_s1    (stall_s1),
		.item_s1     (item_s1),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.shown_code  (shown_code)
	);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the rotating fault-code display scan. Refresh ticks go in and
// shown codes come out, each with random idle and stall bursts except in
// the last phase. A scoreboard keeps its own copy of the scan position,
// dwell counter and dwell setting, and compares every shown code with its
// prediction. The dwell setting changes between phases with nothing in flight.
// ----------------------------------------------------------------------------
module tb;
	import fcrds_pkg::*;

	localparam int WatchdogLimit = 500;
	localparam int PhaseItems    = 62;
	localparam int NumPhases     = 8;

	class code_scoreboard;
		code_t  pending_codes[$];
		dwell_t dwell_setting;
		code_t  scan_pos;
		code_t  last_pos;
		dwell_t dwell_cnt;
		int     errors;
		int     results_seen;

		function new();
			dwell_setting = DwellReset;
			scan_pos      = '0;
			last_pos      = '0;
			dwell_cnt     = '0;
			errors        = 0;
			results_seen  = 0;
		endfunction

		function void set_dwell(dwell_t value);
			dwell_setting = value;
		endfunction

		function int pending();
			return pending_codes.size();
		endfunction

		function code_t predict_code(flags_t flags, logic fault);
			int    p;
			code_t nxt;
			if (!fault)
				return CodeNone;
			if (scan_pos < NumCodes) begin
				p = scan_pos;
				while (p < NumCodes && !(p < FlagPositions && flags[p]))
					p++;
				scan_pos = code_t'(p);
			end
			if (last_pos != scan_pos) begin
				last_pos  = scan_pos;
				dwell_cnt = '0;
			end
			dwell_cnt = dwell_cnt + 1'b1;
			if (dwell_cnt >= dwell_setting) begin
				dwell_cnt = '0;
				nxt       = scan_pos + 1'b1;
				scan_pos  = (nxt > NumCodes) ? '0 : nxt;
				return CodeNone;
			end
			return scan_pos;
		endfunction

		function void note_tick(logic [FlagsLowW-1:0] lo, logic [FlagsHighW-1:0] hi,
				logic fault);
			pending_codes.push_back(predict_code({hi, lo}, fault));
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("MISMATCH %s", msg);
			errors++;
		endtask

		task check_shown(code_t got);
			code_t want;
			results_seen++;
			if (pending_codes.size() == 0) begin
				report($sformatf("result %0d: shown_code %0d with no item waiting",
					results_seen, got));
			end else begin
				want = pending_codes.pop_front();
				if (got !== want)
					report($sformatf("result %0d: shown_code got %0d want %0d",
						results_seen, got, want));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	dwell_t                cfg_wr_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [FlagsLowW-1:0]  flags_low;
	logic [FlagsHighW-1:0] flags_high;
	logic                  any_fault;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	code_t                 shown_code;

	bit             idle_on;
	int             stall_left   = 0;
	int             stuck_cycles = 0;
	code_scoreboard sb;

	dwell_t phase_dwells[NumPhases] = '{16'hFFFF, 16'd2, 16'd1, 16'd5, 16'd10, 16'd0,
		16'd7, 16'd3};

	fault_code_rotating_display_scan_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.flags_low   (flags_low),
		.flags_high  (flags_high),
		.any_fault   (any_fault),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.shown_code  (shown_code)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 11);
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_tick(flags_low, flags_high, any_fault);
			if (out_valid && !out_stall)
				sb.check_shown(shown_code);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WatchdogLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [FlagsLowW-1:0] lo, input logic [FlagsHighW-1:0] hi,
			input logic fault);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		flags_low  <= lo;
		flags_high <= hi;
		any_fault  <= fault;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_dwell(input dwell_t value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_dwell(value);
	endtask

	function automatic flags_t pick_faults();
		flags_t f;
		f = '0;
		case ($urandom_range(0, 5))
			0, 1: repeat ($urandom_range(1, 4)) f[$urandom_range(0, FlagPositions - 1)] = 1'b1;
			2: f = flags_t'({$urandom, $urandom, $urandom, $urandom});
			3: f = '1;
			4: f = '0;
			default: f = flags_t'({$urandom, $urandom, $urandom, $urandom}) &
				flags_t'({$urandom, $urandom, $urandom, $urandom});
		endcase
		return f;
	endfunction

	task automatic run_directed();
		send_item('1, '1, 1'b0);
		send_item('1, '1, 1'b1);
		send_item('0, 36'h8_0000_0000, 1'b1);
		send_item('0, '1, 1'b1);
		write_dwell(16'd1);
		send_item(64'h1, '0, 1'b1);
		send_item(64'h8000_0000_0000_0000, '0, 1'b1);
		send_item('0, 36'h1, 1'b1);
		send_item('0, '0, 1'b1);
		write_dwell(16'd0);
		repeat (3) send_item('1, '1, 1'b1);
		send_item('0, '0, 1'b1);
		write_dwell(16'd3);
		repeat (4) send_item(64'h20, '0, 1'b1);
		send_item(64'h20, '0, 1'b0);
		repeat (4) send_item('0, 36'h8_0000_0000, 1'b1);
		send_item(64'h5555_5555_5555_5555, 36'hA_AAAA_AAAA, 1'b1);
		send_item(64'hAAAA_AAAA_AAAA_AAAA, 36'h5_5555_5555, 1'b1);
	endtask

	task automatic run_phase(input int count);
		flags_t faults;
		faults = pick_faults();
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 11) == 0)
				faults = pick_faults();
			send_item(faults[FlagsLowW-1:0], faults[FlagPositions-1:FlagsLowW],
				$urandom_range(0, 7) != 0);
		end
	endtask

	initial begin
		sb          = new();
		idle_on     = 1'b1;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		flags_low   <= '0;
		flags_high  <= '0;
		any_fault   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		for (int ph = 0; ph < NumPhases; ph++) begin
			write_dwell(phase_dwells[ph]);
			if (ph == NumPhases - 1)
				idle_on = 1'b0;
			run_phase(PhaseItems);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/fcrds_pkg.sv
design/fcrds_in_reg.sv
design/fcrds_core.sv
design/fault_code_rotating_display_scan_top.sv
sim/tb.sv
